// ----- src/tccs_pkg.sv -----
// Package for the text console cursor and scroll core.
// Holds the beat and job types, write kinds, register indexes and sizing constants.
// No dependencies; every other file in src uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

	localparam int COL_W        = 6;
	localparam int ROW_W        = 5;
	localparam int ROW_COUNT    = 32;
	localparam int COLUMNS_DEF  = 60;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [7:0]       NEWLINE_CODE   = 8'd10;
	localparam logic [COL_W-1:0] VIS_ROWS_RESET = 6'd30;
	localparam logic [7:0]       BS_RESET       = 8'd8;

	typedef enum logic [1:0] {
		WK_NONE       = 2'd0,
		WK_CHAR       = 2'd1,
		WK_CHAR_COLOR = 2'd2
	} write_kind_t;

	typedef enum logic {
		CFG_VISIBLE_ROWS = 1'b0,
		CFG_BACKSPACE    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CLEAR_PRE,
		BK_MAIN,
		BK_CLEAR_POST
	} bk_state_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic [7:0] color;
	} char_item_t;

	typedef struct packed {
		logic [1:0]       write_kind;
		logic [COL_W-1:0] write_column;
		logic [ROW_W-1:0] write_row;
		logic [7:0]       write_char;
		logic [7:0]       write_color;
		logic [COL_W-1:0] cursor_column;
		logic [ROW_W-1:0] cursor_row;
		logic [ROW_W-1:0] scroll_offset;
		logic             last;
	} wr_item_t;

	// One classified character: an optional main write, an optional row clear
	// that goes before or after it, and the cursor state every beat reports.
	typedef struct packed {
		logic             main_en;
		logic [1:0]       main_kind;
		logic [COL_W-1:0] main_column;
		logic [ROW_W-1:0] main_row;
		logic [7:0]       main_char;
		logic [7:0]       main_color;
		logic             clr_en;
		logic             clr_first;
		logic [ROW_W-1:0] clr_row;
		logic [COL_W-1:0] cursor_column;
		logic [ROW_W-1:0] cursor_row;
		logic [ROW_W-1:0] scroll_offset;
	} job_t;

endpackage

`default_nettype wire

// ----- src/tccs_front.sv -----
// Front end of the console core: configuration registers, cursor state,
// row end table, and classification of each character into a job.
// Depends on tccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccs_front #(
	parameter int COLUMNS = tccs_pkg::COLUMNS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [7:0]           cfg_wdata,
	input  wire logic                 char_valid,
	input  wire logic                 char_stall,
	input  wire tccs_pkg::char_item_t char_beat,
	input  wire logic                 push_ready,
	output tccs_pkg::job_t            push_job
);

	logic [tccs_pkg::COL_W-1:0] visible_rows_q;
	logic [7:0]                 bs_code_q;
	logic [tccs_pkg::COL_W-1:0] cur_column_q;
	logic [tccs_pkg::ROW_W-1:0] cur_row_q;
	logic [tccs_pkg::ROW_W-1:0] row_offset_q;
	logic                       scrolling_q;
	logic [tccs_pkg::COL_W-1:0] row_end_q [tccs_pkg::ROW_COUNT];

	logic                       accept;
	logic [tccs_pkg::COL_W-1:0] lim;
	logic [tccs_pkg::COL_W-1:0] nr6;
	logic [tccs_pkg::ROW_W-1:0] nr_row;
	logic [tccs_pkg::ROW_W-1:0] prev_row;
	logic                       scroll_n;
	logic                       need_nr;
	logic [tccs_pkg::COL_W-1:0] c1;
	logic [tccs_pkg::COL_W:0]   c2;
	logic [tccs_pkg::COL_W-1:0] col_n;
	logic [tccs_pkg::ROW_W-1:0] row_n;
	logic [tccs_pkg::ROW_W-1:0] off_n;
	logic                       scr_n;
	logic                       re_we;
	logic [tccs_pkg::COL_W-1:0] re_val;
	tccs_pkg::job_t             job;

	assign accept = char_valid && !char_stall && push_ready;

	// Scrolling starts once the next row reaches the visible count, clamped to 32.
	assign lim      = (visible_rows_q > tccs_pkg::COL_W'(tccs_pkg::ROW_COUNT))
	                ? tccs_pkg::COL_W'(tccs_pkg::ROW_COUNT) : visible_rows_q;
	assign nr6      = {1'b0, cur_row_q} + 6'd1;
	assign nr_row   = nr6[tccs_pkg::ROW_W-1:0];
	assign scroll_n = scrolling_q | (nr6 >= lim);
	assign prev_row = cur_row_q - 5'd1;
	assign c1       = cur_column_q - 6'd1;
	assign c2       = {1'b0, cur_column_q} + 7'd1;

	always_comb begin
		need_nr          = 1'b0;
		col_n            = cur_column_q;
		re_we            = 1'b0;
		re_val           = cur_column_q;
		job              = '0;
		job.main_en      = 1'b1;
		job.clr_row      = nr_row;
		if (char_beat.char_code == bs_code_q) begin
			job.main_kind   = tccs_pkg::WK_CHAR;
			job.main_column = c1;
			job.main_row    = cur_row_q;
			col_n           = c1;
			if (c1 == '0) begin
				col_n = row_end_q[prev_row];
			end
		end else if (char_beat.char_code == tccs_pkg::NEWLINE_CODE) begin
			re_we          = 1'b1;
			need_nr        = 1'b1;
			col_n          = 6'd1;
			job.main_kind  = tccs_pkg::WK_NONE;
			job.main_en    = !scroll_n;
			job.clr_en     = scroll_n;
		end else if (cur_column_q >= tccs_pkg::COL_W'(COLUMNS)) begin
			// Cursor already past the last column: wrap before storing.
			need_nr         = 1'b1;
			col_n           = 6'd2;
			job.main_kind   = tccs_pkg::WK_CHAR_COLOR;
			job.main_column = 6'd1;
			job.main_row    = nr_row;
			job.main_char   = char_beat.char_code;
			job.main_color  = char_beat.color;
			job.clr_en      = scroll_n;
			job.clr_first   = 1'b1;
		end else begin
			job.main_kind   = tccs_pkg::WK_CHAR_COLOR;
			job.main_column = cur_column_q;
			job.main_row    = cur_row_q;
			job.main_char   = char_beat.char_code;
			job.main_color  = char_beat.color;
			col_n           = c2[tccs_pkg::COL_W-1:0];
			if (c2 >= (tccs_pkg::COL_W+1)'(COLUMNS)) begin
				re_we      = 1'b1;
				re_val     = tccs_pkg::COL_W'(COLUMNS);
				need_nr    = 1'b1;
				col_n      = 6'd1;
				job.clr_en = scroll_n;
			end
		end

		row_n = cur_row_q;
		off_n = row_offset_q;
		scr_n = scrolling_q;
		if (char_beat.char_code == bs_code_q) begin
			if (c1 == '0) begin
				row_n = prev_row;
			end
		end else if (need_nr) begin
			row_n = nr_row;
			scr_n = scroll_n;
			if (scroll_n) begin
				off_n = row_offset_q + 5'd1;
			end
		end
		job.cursor_column = col_n;
		job.cursor_row    = row_n;
		job.scroll_offset = off_n;
	end

	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visible_rows_q <= tccs_pkg::VIS_ROWS_RESET;
			bs_code_q      <= tccs_pkg::BS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tccs_pkg::CFG_VISIBLE_ROWS: visible_rows_q <= cfg_wdata[tccs_pkg::COL_W-1:0];
				tccs_pkg::CFG_BACKSPACE:    bs_code_q      <= cfg_wdata;
				default:                    bs_code_q      <= bs_code_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_column_q <= 6'd1;
			cur_row_q    <= '0;
			row_offset_q <= '0;
			scrolling_q  <= 1'b0;
			for (int i = 0; i < tccs_pkg::ROW_COUNT; i++) begin
				row_end_q[i] <= '0;
			end
		end else if (accept) begin
			cur_column_q <= col_n;
			cur_row_q    <= row_n;
			row_offset_q <= off_n;
			scrolling_q  <= scr_n;
			if (re_we) begin
				row_end_q[cur_row_q] <= re_val;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/tccs_queue.sv -----
// Short job queue between the front and back ends of the console core.
// Depends on tccs_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module tccs_queue #(
	parameter int DEPTH = tccs_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tccs_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output tccs_pkg::job_t      head_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tccs_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/tccs_back.sv -----
// Back end of the console core: expands one job into its run of memory
// write beats and holds them in the output register. Depends on tccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccs_back #(
	parameter int COLUMNS = tccs_pkg::COLUMNS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire tccs_pkg::job_t head_job,
	output logic                pop,
	output logic                wr_valid,
	input  wire logic           wr_stall,
	output tccs_pkg::wr_item_t  wr_beat
);

	tccs_pkg::bk_state_t        state_q;
	tccs_pkg::bk_state_t        state_n;
	tccs_pkg::job_t             job_q;
	logic [tccs_pkg::COL_W-1:0] clr_col_q;
	logic                       out_valid_q;
	tccs_pkg::wr_item_t         out_q;
	logic                       out_free;
	logic                       clr_done;
	logic                       beat_go;
	tccs_pkg::wr_item_t         beat;

	assign out_free = !out_valid_q || !wr_stall;
	assign clr_done = (clr_col_q == tccs_pkg::COL_W'(COLUMNS - 1));

	always_comb begin
		state_n = state_q;
		case (state_q)
			tccs_pkg::BK_IDLE: begin
				if (!q_empty) begin
					if (head_job.clr_en && head_job.clr_first) begin
						state_n = tccs_pkg::BK_CLEAR_PRE;
					end else if (head_job.main_en) begin
						state_n = tccs_pkg::BK_MAIN;
					end else begin
						state_n = tccs_pkg::BK_CLEAR_POST;
					end
				end
			end
			tccs_pkg::BK_CLEAR_PRE: begin
				if (out_free && clr_done) begin
					state_n = tccs_pkg::BK_MAIN;
				end
			end
			tccs_pkg::BK_MAIN: begin
				if (out_free) begin
					state_n = (job_q.clr_en && !job_q.clr_first)
					        ? tccs_pkg::BK_CLEAR_POST : tccs_pkg::BK_IDLE;
				end
			end
			tccs_pkg::BK_CLEAR_POST: begin
				if (out_free && clr_done) begin
					state_n = tccs_pkg::BK_IDLE;
				end
			end
			default: state_n = tccs_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop                = (state_q == tccs_pkg::BK_IDLE) && !q_empty;
		beat_go            = (state_q != tccs_pkg::BK_IDLE) && out_free;
		beat               = '0;
		beat.cursor_column = job_q.cursor_column;
		beat.cursor_row    = job_q.cursor_row;
		beat.scroll_offset = job_q.scroll_offset;
		case (state_q)
			tccs_pkg::BK_MAIN: begin
				beat.write_kind   = job_q.main_kind;
				beat.write_column = job_q.main_column;
				beat.write_row    = job_q.main_row;
				beat.write_char   = job_q.main_char;
				beat.write_color  = job_q.main_color;
				beat.last         = !(job_q.clr_en && !job_q.clr_first);
			end
			tccs_pkg::BK_CLEAR_PRE, tccs_pkg::BK_CLEAR_POST: begin
				beat.write_kind   = tccs_pkg::WK_CHAR;
				beat.write_column = clr_col_q;
				beat.write_row    = job_q.clr_row;
				beat.last         = (state_q == tccs_pkg::BK_CLEAR_POST) && clr_done;
			end
			default: beat.last = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (beat_go) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tccs_pkg::BK_IDLE;
			clr_col_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (pop) begin
				clr_col_q <= '0;
			end else if (beat_go && (state_q == tccs_pkg::BK_CLEAR_PRE
			                      || state_q == tccs_pkg::BK_CLEAR_POST)) begin
				clr_col_q <= clr_done ? '0 : clr_col_q + 6'd1;
			end
			if (beat_go) begin
				out_valid_q <= 1'b1;
			end else if (!wr_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign wr_valid = out_valid_q;
	assign wr_beat  = out_q;

endmodule

`default_nettype wire

// ----- src/text_console_cursor_scroll_core.sv -----
// Top level of the text console cursor and scroll core.
// Instantiates tccs_front, tccs_queue and tccs_back; depends on tccs_pkg.
//
//   Channel   Direction  Handshake                  Beat content
//   char      in         char_valid / char_stall    char_code, color
//   wr        out        wr_valid / wr_stall        one memory write plus cursor state
//   cfg       in         cfg_we (no wait)           cfg_index, cfg_wdata
//
// A character is classified in the cycle it is accepted and queued as a job.
// The back end then picks up the job and emits one write beat for a plain
// character, backspace or newline that does not scroll; a character that
// scrolls also clears a whole row, one beat per column from the row clear
// loop in the back end, and a scrolling newline makes only those beats.
// Reset clears the cursor to column 1 of row 0, the scroll offset, the
// scrolling flag and the row end table; the first character may arrive in
// the first cycle after reset. A stall on wr holds the output register and
// eventually fills the job queue, which then stalls char.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_scroll_core #(
	parameter int COLUMNS     = tccs_pkg::COLUMNS_DEF,
	parameter int QUEUE_DEPTH = tccs_pkg::QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [7:0]           cfg_wdata,
	input  wire logic                 char_valid,
	output logic                      char_stall,
	input  wire tccs_pkg::char_item_t char_beat,
	output logic                      wr_valid,
	input  wire logic                 wr_stall,
	output tccs_pkg::wr_item_t        wr_beat
);

	tccs_pkg::job_t push_job;
	tccs_pkg::job_t head_job;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic           q_push;

	// The front only stalls on a full queue; each accepted character makes
	// exactly one job.
	assign char_stall = q_full;
	assign q_push     = char_valid && !q_full;

	tccs_front #(
		.COLUMNS(COLUMNS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_beat (char_beat),
		.push_ready(!q_full),
		.push_job  (push_job)
	);

	tccs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head_job(head_job)
	);

	tccs_back #(
		.COLUMNS(COLUMNS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head_job(head_job),
		.pop     (q_pop),
		.wr_valid(wr_valid),
		.wr_stall(wr_stall),
		.wr_beat (wr_beat)
	);

endmodule

`default_nettype wire
